>>> rtl/dcb_pkg.sv
// ----------------------------------------------------------------------------
// dcb_pkg
// Shared types, basis codes and calendar tables of the day-count block.
// ----------------------------------------------------------------------------
package dcb_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DNUM_W  = 22;  // day number, max 3652059
  localparam int unsigned CNT_W   = 23;  // signed day count

  localparam logic [YEAR_W-1:0]  YEAR_MIN = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_ONE  = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LEAP_FEB = 5'd29;
  localparam logic [DAY_W-1:0]   DAY_30   = 5'd30;
  localparam logic [DAY_W-1:0]   DAY_31   = 5'd31;

  // floor(y / 100) = (y * 5243) >> 19, exact for y < 16384
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned CENT_W       = 7;   // century count, max 99

  typedef enum logic [2:0] {
    OP_US30      = 3'd0,
    OP_ACT_ACT   = 3'd1,
    OP_ACT_360   = 3'd2,
    OP_ACT_365   = 3'd3,
    OP_EURO30    = 3'd4,
    OP_EURO30_PL = 3'd5,
    OP_SYM30     = 3'd6,
    OP_US30_ALT  = 3'd7
  } op_t;

  // Cleaned date plus the terms the later stages need
  typedef struct packed {
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [YEAR_W-1:0]  p;        // y - 1
    logic [CENT_W-1:0]  qp;       // (y - 1) / 100
    logic               leap;
    logic               feb_end;
  } cdate_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:                   n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] s;
    unique case (m)
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/dcb_if.sv
// ----------------------------------------------------------------------------
// dcb_in_if / dcb_out_if
// Valid/ready channels carrying date-pair requests and day-count results.
// ----------------------------------------------------------------------------
interface dcb_in_if;
  logic        valid;
  logic        ready;
  logic [13:0] from_year;
  logic [3:0]  from_month;
  logic [4:0]  from_day;
  logic [13:0] to_year;
  logic [3:0]  to_month;
  logic [4:0]  to_day;
  logic [2:0]  op;

  modport source (output valid, from_year, from_month, from_day,
                  to_year, to_month, to_day, op, input ready);
  modport sink   (input valid, from_year, from_month, from_day,
                  to_year, to_month, to_day, op, output ready);
endinterface

interface dcb_out_if;
  logic               valid;
  logic               ready;
  logic signed [22:0] day_count;

  modport source (output valid, day_count, input ready);
  modport sink   (input valid, day_count, output ready);
endinterface

>>> rtl/dcb_clean.sv
// ----------------------------------------------------------------------------
// dcb_clean
// Two stages: saturate fields and find the century, then leap year and
// day clamp.
// ----------------------------------------------------------------------------
module dcb_clean (
  input  logic                clk,
  input  dcb_pkg::stage_en_t  en,
  input  logic [13:0]         year,
  input  logic [3:0]          month,
  input  logic [4:0]          day,
  output dcb_pkg::cdate_t     date
);

  // stage 1
  logic [13:0] y_sat;
  logic [3:0]  m_sat;
  logic [26:0] prod;
  logic [13:0] y_s1_r;
  logic [3:0]  m_s1_r;
  logic [4:0]  d_s1_r;
  logic [6:0]  qy_s1_r;
  logic [6:0]  qy_nxt;

  always_comb begin
    y_sat = year;
    if (year < dcb_pkg::YEAR_MIN) begin
      y_sat = dcb_pkg::YEAR_MIN;
    end else if (year > dcb_pkg::YEAR_MAX) begin
      y_sat = dcb_pkg::YEAR_MAX;
    end
    m_sat = month;
    if (month == 4'd0) begin
      m_sat = 4'd1;
    end else if (month > dcb_pkg::MONTH_DEC) begin
      m_sat = dcb_pkg::MONTH_DEC;
    end
    prod   = 27'(y_sat) * 27'(dcb_pkg::DIV100_MUL);
    qy_nxt = prod[dcb_pkg::DIV100_SHIFT +: dcb_pkg::CENT_W];
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y_s1_r  <= y_sat;
      m_s1_r  <= m_sat;
      d_s1_r  <= day;
      qy_s1_r <= qy_nxt;
    end
  end

  // stage 2
  logic [13:0]     hund;
  logic            cent_year;
  logic            leap;
  logic [4:0]      dim;
  logic [4:0]      d_cl;
  dcb_pkg::cdate_t date_nxt;
  dcb_pkg::cdate_t date_r;

  always_comb begin
    hund      = 14'(qy_s1_r) * 14'd100;
    cent_year = (y_s1_r == hund);
    leap      = (y_s1_r[1:0] == 2'b00) && (!cent_year || (qy_s1_r[1:0] == 2'b00));
    dim       = dcb_pkg::month_len(m_s1_r);
    if (m_s1_r == dcb_pkg::MONTH_FEB && leap) begin
      dim = dcb_pkg::DAY_LEAP_FEB;
    end
    d_cl = d_s1_r;
    if (d_s1_r == 5'd0) begin
      d_cl = dcb_pkg::DAY_ONE;
    end else if (d_s1_r > dim) begin
      d_cl = dim;
    end
    date_nxt.y       = y_s1_r;
    date_nxt.m       = m_s1_r;
    date_nxt.d       = d_cl;
    date_nxt.p       = y_s1_r - 14'd1;
    date_nxt.qp      = qy_s1_r - 7'(cent_year);  // y on a century: one less
    date_nxt.leap    = leap;
    date_nxt.feb_end = (m_s1_r == dcb_pkg::MONTH_FEB) && (d_cl == dim);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      date_r <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

>>> rtl/dcb_order.sv
// ----------------------------------------------------------------------------
// dcb_order
// Day numbers of both dates, date order, swap to earlier/later.
// ----------------------------------------------------------------------------
module dcb_order (
  input  logic                clk,
  input  dcb_pkg::stage_en_t  en,
  input  dcb_pkg::cdate_t     from_date,
  input  dcb_pkg::cdate_t     to_date,
  output dcb_pkg::cdate_t     early,
  output dcb_pkg::cdate_t     late,
  output logic [21:0]         dn_early,
  output logic [21:0]         dn_late,
  output logic                neg
);

  function automatic logic [21:0] day_num(input dcb_pkg::cdate_t c);
    logic [21:0] n;
    n = 22'(c.p) * 22'd365 + 22'(c.p >> 2) - 22'(c.qp) + 22'(c.qp >> 2)
      + 22'(dcb_pkg::month_start(c.m)) + 22'(c.d)
      + 22'(c.leap && (c.m > dcb_pkg::MONTH_FEB));
    return n;
  endfunction

  logic            swap;
  logic [21:0]     dn_from;
  logic [21:0]     dn_to;
  dcb_pkg::cdate_t early_r;
  dcb_pkg::cdate_t late_r;
  logic [21:0]     dn_early_r;
  logic [21:0]     dn_late_r;
  logic            neg_r;

  always_comb begin
    dn_from = day_num(from_date);
    dn_to   = day_num(to_date);
    swap    = {from_date.y, from_date.m, from_date.d} > {to_date.y, to_date.m, to_date.d};
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      early_r    <= swap ? to_date   : from_date;
      late_r     <= swap ? from_date : to_date;
      dn_early_r <= swap ? dn_to     : dn_from;
      dn_late_r  <= swap ? dn_from   : dn_to;
      neg_r      <= swap;
    end
  end

  assign early    = early_r;
  assign late     = late_r;
  assign dn_early = dn_early_r;
  assign dn_late  = dn_late_r;
  assign neg      = neg_r;

endmodule

>>> rtl/dcb_basis.sv
// ----------------------------------------------------------------------------
// dcb_basis
// Basis-specific day adjustment and count, then sign and output register.
// ----------------------------------------------------------------------------
module dcb_basis (
  input  logic                clk,
  input  dcb_pkg::stage_en_t  en,
  input  dcb_pkg::op_t        op,
  input  dcb_pkg::cdate_t     early,
  input  dcb_pkg::cdate_t     late,
  input  logic [21:0]         dn_early,
  input  logic [21:0]         dn_late,
  input  logic                neg,
  output logic signed [22:0]  day_count
);

  logic [4:0]  us_d1, us_d2, sym_d1, sym_d2;
  logic [4:0]  d1, d2;
  logic [4:0]  m2;
  logic        us_same;
  logic        use_actual;
  logic [23:0] dy, dm, dd, total;
  logic [22:0] r_nxt;
  logic [22:0] r_r;
  logic        neg_s4_r;
  logic [22:0] out_r;

  always_comb begin
    // US: day 31 start folds, end folds only after a 30/31 start,
    // February month-end start (and end) counts as 30
    us_same = (early.y == late.y) && (early.m == late.m) && (early.d == late.d);
    us_d1   = (early.d == dcb_pkg::DAY_31) ? dcb_pkg::DAY_30 : early.d;
    us_d2   = (late.d == dcb_pkg::DAY_31 && us_d1 == dcb_pkg::DAY_30) ?
              dcb_pkg::DAY_30 : late.d;
    if (early.feb_end) begin
      if (late.feb_end) begin
        us_d2 = dcb_pkg::DAY_30;
      end
      us_d1 = dcb_pkg::DAY_30;
    end

    // symmetric: February month-end on either side first
    sym_d1 = early.feb_end ? dcb_pkg::DAY_30 : early.d;
    sym_d2 = late.feb_end  ? dcb_pkg::DAY_30 : late.d;
    if (sym_d2 == dcb_pkg::DAY_31 && sym_d1 >= dcb_pkg::DAY_30) begin
      sym_d2 = dcb_pkg::DAY_30;
    end
    if (sym_d1 == dcb_pkg::DAY_31) begin
      sym_d1 = dcb_pkg::DAY_30;
    end

    use_actual = 1'b0;
    m2         = 5'(late.m);
    d1         = us_d1;
    d2         = us_d2;
    unique case (op)
      dcb_pkg::OP_ACT_ACT, dcb_pkg::OP_ACT_360, dcb_pkg::OP_ACT_365: begin
        use_actual = 1'b1;
      end
      dcb_pkg::OP_EURO30: begin
        d1 = (early.d == dcb_pkg::DAY_31) ? dcb_pkg::DAY_30 : early.d;
        d2 = (late.d  == dcb_pkg::DAY_31) ? dcb_pkg::DAY_30 : late.d;
      end
      dcb_pkg::OP_EURO30_PL: begin
        d1 = (early.d == dcb_pkg::DAY_31) ? dcb_pkg::DAY_30 : early.d;
        d2 = late.d;
        if (late.d == dcb_pkg::DAY_31) begin
          d2 = dcb_pkg::DAY_ONE;
          m2 = 5'(late.m) + 5'd1;
        end
      end
      dcb_pkg::OP_SYM30: begin
        d1 = sym_d1;
        d2 = sym_d2;
      end
      dcb_pkg::OP_US30, dcb_pkg::OP_US30_ALT: begin
        d1 = us_d1;
        d2 = us_d2;
      end
    endcase

    // two's complement, so unsigned wrap gives the signed sum
    dy    = 24'(late.y) - 24'(early.y);
    dm    = 24'(m2) - 24'(early.m);
    dd    = 24'(d2) - 24'(d1);
    total = dy * 24'd360 + dm * 24'd30 + dd;

    if (use_actual) begin
      r_nxt = 23'(dn_late) - 23'(dn_early);
    end else if (us_same && (op == dcb_pkg::OP_US30 || op == dcb_pkg::OP_US30_ALT)) begin
      r_nxt = '0;
    end else begin
      r_nxt = total[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      r_r      <= r_nxt;
      neg_s4_r <= neg;
    end
    if (en.s5) begin
      out_r <= neg_s4_r ? (23'd0 - r_r) : r_r;
    end
  end

  assign day_count = $signed(out_r);

endmodule

>>> rtl/day_count_basis_difference.sv
// Result path: an accepted request passes five register stages, s1 to s5, to result valid.
// Throughput: one request per cycle while the output is not stalled; every stage holds one request.
// The rate is set by the five-stage pipe; per-stage ready lets a stage fill
// whenever the stage after it is empty or moving, so bubbles close up.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// day_count_basis_difference
// Signed day count between two dates under a 30/360 or actual basis.
// ----------------------------------------------------------------------------
module day_count_basis_difference (
  input  logic          clk,
  input  logic          rst_n,
  dcb_in_if.sink        in_ch,
  dcb_out_if.source     out_ch
);

  // Pipe layout:
  //   s1  saturate year/month, century of year (one 14x13 multiply per date)
  //   s2  leap year, day clamp, last day of February
  //   s3  day numbers of both dates, order compare, swap
  //   s4  basis day adjustment and 360/30/1 weighted sum
  //   s5  negate when swapped, output register

  dcb_pkg::stage_en_t en;
  logic v_s1_r, v_s2_r, v_s3_r, v_s4_r, v_s5_r;
  logic [2:0] op_s1_r, op_s2_r, op_s3_r;

  dcb_pkg::cdate_t from_date, to_date;
  dcb_pkg::cdate_t early, late;
  logic [21:0]     dn_early, dn_late;
  logic            neg;

  // A stage loads when it is empty or its contents move on this edge.
  always_comb begin
    en.s5 = !v_s5_r || out_ch.ready;
    en.s4 = !v_s4_r || en.s5;
    en.s3 = !v_s3_r || en.s4;
    en.s2 = !v_s2_r || en.s3;
    en.s1 = !v_s1_r || en.s2;
  end

  assign in_ch.ready  = en.s1;
  assign out_ch.valid = v_s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0;
      v_s2_r <= 1'b0;
      v_s3_r <= 1'b0;
      v_s4_r <= 1'b0;
      v_s5_r <= 1'b0;
    end else begin
      if (en.s1) begin
        v_s1_r <= in_ch.valid;
      end
      if (en.s2) begin
        v_s2_r <= v_s1_r;
      end
      if (en.s3) begin
        v_s3_r <= v_s2_r;
      end
      if (en.s4) begin
        v_s4_r <= v_s3_r;
      end
      if (en.s5) begin
        v_s5_r <= v_s4_r;
      end
    end
  end

  // basis code rides along until the basis stage
  always_ff @(posedge clk) begin
    if (en.s1) begin
      op_s1_r <= in_ch.op;
    end
    if (en.s2) begin
      op_s2_r <= op_s1_r;
    end
    if (en.s3) begin
      op_s3_r <= op_s2_r;
    end
  end

  dcb_clean u_clean_from (
    .clk   (clk),
    .en    (en),
    .year  (in_ch.from_year),
    .month (in_ch.from_month),
    .day   (in_ch.from_day),
    .date  (from_date)
  );

  dcb_clean u_clean_to (
    .clk   (clk),
    .en    (en),
    .year  (in_ch.to_year),
    .month (in_ch.to_month),
    .day   (in_ch.to_day),
    .date  (to_date)
  );

  dcb_order u_order (
    .clk       (clk),
    .en        (en),
    .from_date (from_date),
    .to_date   (to_date),
    .early     (early),
    .late      (late),
    .dn_early  (dn_early),
    .dn_late   (dn_late),
    .neg       (neg)
  );

  dcb_basis u_basis (
    .clk       (clk),
    .en        (en),
    .op        (dcb_pkg::op_t'(op_s3_r)),
    .early     (early),
    .late      (late),
    .dn_early  (dn_early),
    .dn_late   (dn_late),
    .neg       (neg),
    .day_count (out_ch.day_count)
  );

`ifndef SYNTH
  // full pipe behind a stalled output must refuse new requests
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v_s1_r && v_s2_r && v_s3_r && v_s4_r && v_s5_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("request accepted into a full stalled pipe");

  // an accepted request lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_s1_r)
    else $error("accepted request lost at stage 1");

  // a taken result with nothing behind it is not shown again
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !v_s4_r) |=> !out_ch.valid)
    else $error("result repeated");

  // count stays within the span of the year range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.day_count >= -23'sd3652059 &&
                      out_ch.day_count <= 23'sd3652059))
    else $error("day count out of range");
`endif

endmodule
